[rtl/core/slew_limited_position_controller_macros.svh]
// ----------------------------------------------------------------------------
// Slew-limited position controller assertion macros
// Shared concurrent assertion forms used by the controller RTL.
// ----------------------------------------------------------------------------
`ifndef SLEW_LIMITED_POSITION_CONTROLLER_MACROS_SVH
`define SLEW_LIMITED_POSITION_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/slc_pkg.sv]
// ----------------------------------------------------------------------------
// Slew-limited position controller package
// Shared constants, register codes and item types.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

  localparam int unsigned SLC_GAIN_FRAC_BITS = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN         = 3'd0,
    REG_SPEED_LIMIT  = 3'd1,
    REG_ACCEL_PER_MS = 3'd2,
    REG_TOLERANCE    = 3'd3
  } cfg_reg_e;

  localparam logic [15:0] GAIN_RST         = 16'd256;
  localparam logic [30:0] SPEED_LIMIT_RST  = 31'd655360;
  localparam logic [23:0] ACCEL_PER_MS_RST = 24'd3277;
  localparam logic [30:0] TOLERANCE_RST    = 31'd655;

  typedef struct packed {
    logic [15:0] gain;
    logic [30:0] speed_limit;
    logic [23:0] accel_per_ms;
    logic [30:0] tolerance;
  } cfg_t;

  typedef struct packed {
    logic [31:0] setpoint_pos;
    logic [31:0] measured_position;
    logic [9:0]  elapsed_ms;
    logic        restart;
  } in_item_t;

  typedef struct packed {
    logic [31:0] speed_command;
    logic        target_reached;
  } res_item_t;

  typedef struct packed {
    logic advance;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/slc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// Gain, speed limit, acceleration step and tolerance, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_cfg_regs
  import slc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GAIN:         cfg_d.gain         = cfg_wdata_i[15:0];
        REG_SPEED_LIMIT:  cfg_d.speed_limit  = cfg_wdata_i[30:0];
        REG_ACCEL_PER_MS: cfg_d.accel_per_ms = cfg_wdata_i[23:0];
        REG_TOLERANCE:    cfg_d.tolerance    = cfg_wdata_i[30:0];
        default:          cfg_d = cfg_q;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain         <= GAIN_RST;
      cfg_q.speed_limit  <= SPEED_LIMIT_RST;
      cfg_q.accel_per_ms <= ACCEL_PER_MS_RST;
      cfg_q.tolerance    <= TOLERANCE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/core/slc_in_stage.sv]
// ----------------------------------------------------------------------------
// Input stage
// Registers one accepted tick item ahead of the control datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_in_stage
  import slc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  input  pipe_ctrl_t ctrl_i,
  output logic      s1_valid_o,
  output in_item_t  s1_item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     accept;

  assign in_ready_o = !valid_q || ctrl_i.advance;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (ctrl_i.advance) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_item_o  = item_q;

endmodule

`default_nettype wire

[rtl/core/slc_datapath.sv]
// ----------------------------------------------------------------------------
// Control datapath
// Error, tolerance test, gain scaling, speed clamp and slew limit.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_datapath
  import slc_pkg::*;
#(
  parameter int unsigned GAIN_FRAC_BITS = SLC_GAIN_FRAC_BITS
) (
  input  in_item_t           item_i,
  input  cfg_t               cfg_i,
  input  wire logic [31:0]   prev_speed_i,
  output res_item_t          res_o
);

  logic signed [32:0] err;
  logic               neg;
  logic        [32:0] mag;
  logic               reached;
  logic        [48:0] prod;
  logic        [48:0] scaled_full;
  logic        [30:0] scaled;
  logic signed [32:0] desired;
  logic        [33:0] change;
  logic signed [31:0] prev;
  logic signed [34:0] diff;
  logic signed [34:0] change_s;
  logic signed [35:0] prev_x;
  logic signed [35:0] change_x;
  logic signed [35:0] cmd;
  logic        [31:0] cmd_sat;

  // 33-bit error never wraps
  assign err = $signed({item_i.setpoint_pos[31], item_i.setpoint_pos})
             - $signed({item_i.measured_position[31], item_i.measured_position});
  assign neg = err[32];
  assign mag = neg ? 33'(-err) : 33'(err);

  assign reached = mag <= {2'b00, cfg_i.tolerance};

  assign prod        = 49'(mag) * 49'(cfg_i.gain);
  assign scaled_full = prod >> GAIN_FRAC_BITS;
  assign scaled      = (scaled_full > {18'd0, cfg_i.speed_limit}) ? cfg_i.speed_limit
                                                                 : scaled_full[30:0];
  assign desired     = neg ? -$signed({2'b00, scaled}) : $signed({2'b00, scaled});

  assign change = 34'(cfg_i.accel_per_ms) * 34'(item_i.elapsed_ms);
  assign prev   = item_i.restart ? 32'sd0 : $signed(prev_speed_i);

  assign diff     = 35'(desired) - 35'(prev);
  assign change_s = $signed({1'b0, change});
  assign prev_x   = 36'(prev);
  assign change_x = $signed({2'b00, change});

  always_comb begin
    if (diff > change_s) begin
      cmd = prev_x + change_x;
    end else if (diff < -change_s) begin
      cmd = prev_x - change_x;
    end else begin
      cmd = 36'(desired);
    end
  end

  always_comb begin
    if (cmd > 36'sh0_7FFF_FFFF) begin
      cmd_sat = 32'h7FFF_FFFF;
    end else if (cmd < -36'sh0_8000_0000) begin
      cmd_sat = 32'h8000_0000;
    end else begin
      cmd_sat = cmd[31:0];
    end
  end

  always_comb begin
    if (reached) begin
      res_o.speed_command  = '0;
      res_o.target_reached = 1'b1;
    end else begin
      res_o.speed_command  = cmd_sat;
      res_o.target_reached = 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/core/slc_out_stage.sv]
// ----------------------------------------------------------------------------
// Output stage
// Result register and the stored last speed command.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_out_stage
  import slc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  pipe_ctrl_t ctrl_i,
  input  res_item_t  res_i,
  input  wire logic  out_ready_i,
  output logic       out_valid_o,
  output res_item_t  res_o,
  output logic [31:0] prev_speed_o
);

  logic        valid_q, valid_d;
  res_item_t   res_q;
  logic [31:0] prev_q;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.advance) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // the last command is the speed state for the next tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      prev_q  <= '0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.advance) begin
        prev_q <= res_i.speed_command;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign res_o        = res_q;
  assign prev_speed_o = prev_q;

endmodule

`default_nettype wire

[rtl/core/slew_limited_position_controller.sv]
// Flow: a tick accepted into the input register moves on into the result register
//   when the result slot is free or being emptied.
// Throughput: one tick per cycle unless out_ready_i stalls the result register;
//   the stored last speed command carries the speed from one tick to the next.
// Reset: clears both valid flags and the stored speed; configuration returns to
//   gain 1.0, speed limit 10 rad/s, accel 0.05 rad/s per ms, tolerance 0.01 rad.
// ----------------------------------------------------------------------------
// Slew-limited position controller
// Proportional position loop with speed clamp and acceleration limit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "slew_limited_position_controller_macros.svh"

module slew_limited_position_controller
  import slc_pkg::*;
#(
  parameter int unsigned GAIN_FRAC_BITS = SLC_GAIN_FRAC_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [31:0]           target_position_i,
  input  wire logic [31:0]           measured_position_i,
  input  wire logic [9:0]            elapsed_ms_i,
  input  wire logic                  restart_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [31:0]                speed_command_o,
  output logic                       target_reached_o
);

  cfg_t        cfg;
  in_item_t    in_item;
  in_item_t    s1_item;
  logic        s1_valid;
  pipe_ctrl_t  ctrl;
  res_item_t   res_comb;
  res_item_t   res_q;
  logic [31:0] prev_speed;

  assign in_item.setpoint_pos      = target_position_i;
  assign in_item.measured_position = measured_position_i;
  assign in_item.elapsed_ms        = elapsed_ms_i;
  assign in_item.restart           = restart_i;

  // advance when the input stage holds a tick and the result slot is free or being emptied
  assign ctrl.advance = s1_valid && (!out_valid_o || out_ready_i);

  slc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  slc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .ctrl_i     (ctrl),
    .s1_valid_o (s1_valid),
    .s1_item_o  (s1_item)
  );

  slc_datapath #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .item_i       (s1_item),
    .cfg_i        (cfg),
    .prev_speed_i (prev_speed),
    .res_o        (res_comb)
  );

  slc_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .res_i        (res_comb),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .res_o        (res_q),
    .prev_speed_o (prev_speed)
  );

  assign speed_command_o  = res_q.speed_command;
  assign target_reached_o = res_q.target_reached;

  `SLC_ASSERT_NOW(a_reached_zero, clk_i, rst_ni, out_valid_o && target_reached_o,
    speed_command_o == 32'd0, "reached item carries nonzero speed")
  `SLC_ASSERT_NOW(a_prev_tracks_out, clk_i, rst_ni, out_valid_o,
    prev_speed == speed_command_o, "stored speed differs from shown command")
  `SLC_ASSERT_NEXT(a_s1_holds, clk_i, rst_ni, s1_valid && out_valid_o && !out_ready_i,
    s1_valid && $stable(s1_item), "stalled item lost from input stage")

endmodule

`default_nettype wire
